// ===== hw/rtl/lav_pkg.sv =====
package lav_pkg;

	localparam int VW  = 52;            // signed component into a normaliser
	localparam int MW  = VW;            // magnitude width
	localparam int PW  = $clog2(MW);    // leading-one position
	localparam int NB  = 31;            // block-scaled magnitude
	localparam int SW  = 64;            // sum of squares
	localparam int RW  = 32;            // square root
	localparam int QW  = 17;            // quotient
	localparam int DW  = 49;            // dividend
	localparam int UW  = 18;            // unit component

	localparam int UNIT_LAT = 4 + RW + 1 + QW + 1 + 1;
	localparam int XL       = 2;
	localparam int UP_D     = UNIT_LAT;
	localparam int R_D      = XL + UNIT_LAT;
	localparam int F_D      = 2 * (XL + UNIT_LAT);
	localparam int EYE_D    = 3 * UNIT_LAT + 2 * XL;

	typedef logic signed [VW-1:0] comp_t;
	typedef logic signed [UW-1:0] unit_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec32_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} sgn_t;

endpackage

// ===== hw/rtl/look_at_view_matrix_unit.sv =====
// Look-at view basis: one camera setup (eye, target, up hint, Q16.16) per
// beat in, one basis (right, corrected up, forward, Q2.16 unit vectors) plus
// three saturated translations per beat out. Fully pipelined: a new setup is
// taken every cycle unless the output is held. The pipeline depth is set by
// the three chained normalisers, each a 32-stage square root and a 17-stage
// divider; a held output stalls the whole pipeline.
module look_at_view_matrix_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] upward_x,
	input  logic signed [31:0] upward_y,
	input  logic signed [31:0] upward_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] right_x,
	output logic signed [17:0] right_y,
	output logic signed [17:0] right_z,
	output logic signed [17:0] ortho_up_x,
	output logic signed [17:0] ortho_up_y,
	output logic signed [17:0] ortho_up_z,
	output logic signed [17:0] forward_x,
	output logic signed [17:0] forward_y,
	output logic signed [17:0] forward_z,
	output logic signed [31:0] shift_right,
	output logic signed [31:0] shift_up,
	output logic signed [31:0] shift_forward
);

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic f_valid, r_valid, u_valid;

	logic signed [32:0] d_s1 [3];
	lav_pkg::vec32_t    eye_s1, up_s1;
	lav_pkg::comp_t     d_comp [3];

	lav_pkg::vec32_t    up_q  [lav_pkg::UP_D];
	lav_pkg::vec32_t    eye_q [lav_pkg::EYE_D];
	lav_pkg::unit_t     f_q   [lav_pkg::F_D][3];
	lav_pkg::unit_t     r_q   [lav_pkg::R_D][3];

	lav_pkg::unit_t     f_u [3], r_u [3], u_u [3];
	lav_pkg::vec32_t    up_a, eye_a;

	logic signed [49:0] pa_s2 [3], pb_s2 [3];
	lav_pkg::comp_t     c_s3 [3];
	logic signed [35:0] pa_s4 [3], pb_s4 [3];
	lav_pkg::comp_t     c_s5 [3];

	logic signed [49:0] dot_s6 [3][3];
	lav_pkg::unit_t     bas_s6 [3][3];
	logic signed [51:0] sum_s7 [3];
	lav_pkg::unit_t     bas_s7 [3][3];
	lav_pkg::unit_t     bas_s8 [3][3];
	logic signed [31:0] shf_s8 [3];

	logic signed [52:0] rnd [3];
	logic signed [36:0] qt [3];
	logic signed [31:0] sat [3];

	assign en       = !v_s8 || out_ready;
	assign in_ready = en;
	assign out_valid = v_s8;

	assign up_a  = up_q[lav_pkg::UP_D-1];
	assign eye_a = eye_q[lav_pkg::EYE_D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= f_valid;
			v_s3 <= v_s2;
			v_s4 <= r_valid;
			v_s5 <= v_s4;
			v_s6 <= u_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_comp[i] = lav_pkg::comp_t'(d_s1[i]);
		end
	end

	lav_unit u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_comp   (d_comp),
		.out_valid (f_valid),
		.out_unit  (f_u)
	);

	lav_unit u_rgt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_comp   (c_s3),
		.out_valid (r_valid),
		.out_unit  (r_u)
	);

	lav_unit u_oup (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_comp   (c_s5),
		.out_valid (u_valid),
		.out_unit  (u_u)
	);

	// translation: negate, round to Q16.16, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = -53'(sum_s7[i]) + 53'sd32768;
			qt[i]  = 37'(rnd[i] >>> 16);
			if (qt[i] > 37'sd2147483647) begin
				sat[i] = 32'sh7fffffff;
			end else if (qt[i] < -37'sd2147483648) begin
				sat[i] = 32'sh80000000;
			end else begin
				sat[i] = 32'(qt[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(eye_x) - 33'(target_x);
			d_s1[1] <= 33'(eye_y) - 33'(target_y);
			d_s1[2] <= 33'(eye_z) - 33'(target_z);
			eye_s1  <= '{x: eye_x, y: eye_y, z: eye_z};
			up_s1   <= '{x: upward_x, y: upward_y, z: upward_z};

			up_q[0] <= up_s1;
			for (int k = 1; k < lav_pkg::UP_D; k++) begin
				up_q[k] <= up_q[k-1];
			end
			eye_q[0] <= eye_s1;
			for (int k = 1; k < lav_pkg::EYE_D; k++) begin
				eye_q[k] <= eye_q[k-1];
			end
			f_q[0] <= f_u;
			for (int k = 1; k < lav_pkg::F_D; k++) begin
				f_q[k] <= f_q[k-1];
			end
			r_q[0] <= r_u;
			for (int k = 1; k < lav_pkg::R_D; k++) begin
				r_q[k] <= r_q[k-1];
			end

			// right = up x forward
			pa_s2[0] <= up_a.y * f_u[2];
			pb_s2[0] <= up_a.z * f_u[1];
			pa_s2[1] <= up_a.z * f_u[0];
			pb_s2[1] <= up_a.x * f_u[2];
			pa_s2[2] <= up_a.x * f_u[1];
			pb_s2[2] <= up_a.y * f_u[0];
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= lav_pkg::comp_t'(pa_s2[i]) - lav_pkg::comp_t'(pb_s2[i]);
			end

			// corrected up = forward x right
			pa_s4[0] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][1] * r_u[2];
			pb_s4[0] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][2] * r_u[1];
			pa_s4[1] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][2] * r_u[0];
			pb_s4[1] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][0] * r_u[2];
			pa_s4[2] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][0] * r_u[1];
			pb_s4[2] <= f_q[lav_pkg::XL+lav_pkg::UNIT_LAT-1][1] * r_u[0];
			for (int i = 0; i < 3; i++) begin
				c_s5[i] <= lav_pkg::comp_t'(pa_s4[i]) - lav_pkg::comp_t'(pb_s4[i]);
			end

			bas_s6[0] <= r_q[lav_pkg::R_D-1];
			bas_s6[1] <= u_u;
			bas_s6[2] <= f_q[lav_pkg::F_D-1];
			for (int i = 0; i < 3; i++) begin
				dot_s6[0][i] <= eye_a.x * ((i == 0) ? r_q[lav_pkg::R_D-1][0] :
					(i == 1) ? u_u[0] : f_q[lav_pkg::F_D-1][0]);
				dot_s6[1][i] <= eye_a.y * ((i == 0) ? r_q[lav_pkg::R_D-1][1] :
					(i == 1) ? u_u[1] : f_q[lav_pkg::F_D-1][1]);
				dot_s6[2][i] <= eye_a.z * ((i == 0) ? r_q[lav_pkg::R_D-1][2] :
					(i == 1) ? u_u[2] : f_q[lav_pkg::F_D-1][2]);
			end

			for (int i = 0; i < 3; i++) begin
				sum_s7[i] <= 52'(dot_s6[0][i]) + 52'(dot_s6[1][i]) + 52'(dot_s6[2][i]);
			end
			bas_s7 <= bas_s6;

			bas_s8 <= bas_s7;
			shf_s8 <= sat;
		end
	end

	assign right_x       = bas_s8[0][0];
	assign right_y       = bas_s8[0][1];
	assign right_z       = bas_s8[0][2];
	assign ortho_up_x    = bas_s8[1][0];
	assign ortho_up_y    = bas_s8[1][1];
	assign ortho_up_z    = bas_s8[1][2];
	assign forward_x     = bas_s8[2][0];
	assign forward_y     = bas_s8[2][1];
	assign forward_z     = bas_s8[2][2];
	assign shift_right   = shf_s8[0];
	assign shift_up      = shf_s8[1];
	assign shift_forward = shf_s8[2];

endmodule

// ===== hw/rtl/lav_unit.sv =====
module lav_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  lav_pkg::comp_t    in_comp [3],
	output logic              out_valid,
	output lav_pkg::unit_t    out_unit [3]
);

	logic [lav_pkg::UNIT_LAT-1:0] valid_q;

	logic [lav_pkg::MW-1:0] mag_s1 [3];
	logic [lav_pkg::MW-1:0] mag_s2 [3];
	logic [lav_pkg::NB-1:0] mag_s3 [3];
	logic [lav_pkg::NB-1:0] mag_s4 [3];
	logic [2*lav_pkg::NB-1:0] sqr_s4 [3];
	lav_pkg::sgn_t sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic [lav_pkg::PW-1:0] msb_s2;

	logic [lav_pkg::MW-1:0] orw;
	logic [lav_pkg::PW-1:0] msb;

	logic [lav_pkg::SW-1:0]  sq_rem  [lav_pkg::RW];
	logic [lav_pkg::RW-1:0]  sq_root [lav_pkg::RW+1];
	logic [lav_pkg::NB-1:0]  sq_mag  [lav_pkg::RW+1][3];
	lav_pkg::sgn_t           sq_sgn  [lav_pkg::RW+1];
	logic [lav_pkg::SW-1:0]  sq_nrem [lav_pkg::RW];
	logic [lav_pkg::RW-1:0]  sq_nroot [lav_pkg::RW];

	logic [lav_pkg::DW-1:0]  dv_rem  [lav_pkg::QW][3];
	logic [lav_pkg::RW-1:0]  dv_root [lav_pkg::QW];
	logic [lav_pkg::QW-1:0]  dv_q    [lav_pkg::QW+1][3];
	lav_pkg::sgn_t           dv_sgn  [lav_pkg::QW+1];
	logic [lav_pkg::DW-1:0]  dv_nrem [lav_pkg::QW][3];
	logic [lav_pkg::QW-1:0]  dv_nq   [lav_pkg::QW][3];

	lav_pkg::unit_t          unit_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[lav_pkg::UNIT_LAT-2:0], in_valid};
		end
	end

	assign out_valid = valid_q[lav_pkg::UNIT_LAT-1];
	assign out_unit  = unit_s9;

	// leading one of the largest magnitude
	always_comb begin
		orw = mag_s1[0] | mag_s1[1] | mag_s1[2];
		msb = '0;
		for (int b = 0; b < lav_pkg::MW; b++) begin
			if (orw[b]) begin
				msb = lav_pkg::PW'(b);
			end
		end
	end

	// square root, one result bit per stage
	always_comb begin
		int k;
		logic [lav_pkg::SW+1:0] trial;
		for (int j = 0; j < lav_pkg::RW; j++) begin
			k = lav_pkg::RW - 1 - j;
			trial = ((lav_pkg::SW+2)'(sq_root[j]) << (k + 1))
				| ((lav_pkg::SW+2)'(1) << (2 * k));
			if ((lav_pkg::SW+2)'(sq_rem[j]) >= trial) begin
				sq_nrem[j]  = lav_pkg::SW'((lav_pkg::SW+2)'(sq_rem[j]) - trial);
				sq_nroot[j] = sq_root[j] | (lav_pkg::RW'(1) << k);
			end else begin
				sq_nrem[j]  = sq_rem[j];
				sq_nroot[j] = sq_root[j];
			end
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		int k;
		logic [lav_pkg::DW-1:0] dsh;
		for (int j = 0; j < lav_pkg::QW; j++) begin
			k = lav_pkg::QW - 1 - j;
			dsh = lav_pkg::DW'(dv_root[j]) << k;
			for (int i = 0; i < 3; i++) begin
				if (dv_rem[j][i] >= dsh) begin
					dv_nrem[j][i] = dv_rem[j][i] - dsh;
					dv_nq[j][i]   = dv_q[j][i] | (lav_pkg::QW'(1) << k);
				end else begin
					dv_nrem[j][i] = dv_rem[j][i];
					dv_nq[j][i]   = dv_q[j][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_comp[i][lav_pkg::VW-1] ?
					lav_pkg::MW'(-in_comp[i]) : lav_pkg::MW'(in_comp[i]);
				sgn_s1.neg[i] <= in_comp[i][lav_pkg::VW-1];
			end
			sgn_s1.zero <= (in_comp[0] == '0) && (in_comp[1] == '0) && (in_comp[2] == '0);

			mag_s2 <= mag_s1;
			msb_s2 <= msb;
			sgn_s2 <= sgn_s1;

			for (int i = 0; i < 3; i++) begin
				if (msb_s2 >= lav_pkg::PW'(lav_pkg::NB - 1)) begin
					mag_s3[i] <= lav_pkg::NB'(mag_s2[i]
						>> (msb_s2 - lav_pkg::PW'(lav_pkg::NB - 1)));
				end else begin
					mag_s3[i] <= lav_pkg::NB'(mag_s2[i]
						<< (lav_pkg::PW'(lav_pkg::NB - 1) - msb_s2));
				end
			end
			sgn_s3 <= sgn_s2;

			for (int i = 0; i < 3; i++) begin
				sqr_s4[i] <= mag_s3[i] * mag_s3[i];
			end
			mag_s4 <= mag_s3;
			sgn_s4 <= sgn_s3;

			sq_rem[0]  <= lav_pkg::SW'(sqr_s4[0]) + lav_pkg::SW'(sqr_s4[1])
				+ lav_pkg::SW'(sqr_s4[2]);
			sq_root[0] <= '0;
			sq_mag[0]  <= mag_s4;
			sq_sgn[0]  <= sgn_s4;
			for (int j = 0; j < lav_pkg::RW; j++) begin
				if (j < lav_pkg::RW - 1) begin
					sq_rem[j+1] <= sq_nrem[j];
				end
				sq_root[j+1] <= sq_nroot[j];
				sq_mag[j+1]  <= sq_mag[j];
				sq_sgn[j+1]  <= sq_sgn[j];
			end

			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= (lav_pkg::DW'(sq_mag[lav_pkg::RW][i]) << 16)
					+ lav_pkg::DW'(sq_root[lav_pkg::RW] >> 1);
				dv_q[0][i]   <= '0;
			end
			dv_root[0] <= sq_root[lav_pkg::RW];
			dv_sgn[0]  <= sq_sgn[lav_pkg::RW];
			for (int j = 0; j < lav_pkg::QW; j++) begin
				if (j < lav_pkg::QW - 1) begin
					dv_rem[j+1]  <= dv_nrem[j];
					dv_root[j+1] <= dv_root[j];
				end
				dv_q[j+1]   <= dv_nq[j];
				dv_sgn[j+1] <= dv_sgn[j];
			end

			for (int i = 0; i < 3; i++) begin
				if (dv_sgn[lav_pkg::QW].zero) begin
					unit_s9[i] <= '0;
				end else if (dv_sgn[lav_pkg::QW].neg[i]) begin
					unit_s9[i] <= -lav_pkg::UW'(dv_q[lav_pkg::QW][i]);
				end else begin
					unit_s9[i] <= lav_pkg::UW'(dv_q[lav_pkg::QW][i]);
				end
			end
		end
	end

endmodule
